// ===== hw/rtl/rock_pkg.sv =====
// ----------------------------------------------------------------------------
// rock_pkg: shared types and constants of the recency ordered key cache
// Item formats, operation/status/policy codes, register indexes, the LFSR
// step and the capacity clamp.
// ----------------------------------------------------------------------------
package rock_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_BITS  = 31;
  localparam int POS_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;
  localparam int POLICY_W   = 2;
  localparam int CAP_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam int LFSR_W    = 16;
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = LFSR_W / MOD_BITS;
  localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

  localparam logic [POLICY_W-1:0] POL_LRU  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_MRU  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_RAND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [KEY_BITS-1:0] key;
  } rock_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                evicted_valid;
    logic [KEY_BITS-1:0] evicted_key;
    logic [OCC_W-1:0]    occupancy;
  } rock_out_t;

  // per-cell update controls
  typedef struct packed {
    logic shift;  // take the right neighbor's key
    logic load;   // take the incoming key
  } rock_cell_ctl_t;

  // Galois LFSR, shifted right
  function automatic logic [LFSR_W-1:0] rock_lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

  // 0 acts as 1, anything above CAPACITY acts as CAPACITY
  function automatic logic [CNT_W-1:0] rock_limit(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] lim;
    if (cap == '0) begin
      lim = CNT_W'(1);
    end else if (int'(cap) > CAPACITY) begin
      lim = CNT_W'(CAPACITY);
    end else begin
      lim = CNT_W'(cap);
    end
    return lim;
  endfunction

endpackage

// ===== hw/rtl/rock_cell.sv =====
// ----------------------------------------------------------------------------
// rock_cell: one entry of the recency list
// Holds one key, compares it with the probe key, and shifts left or loads.
// ----------------------------------------------------------------------------
module rock_cell
  import rock_pkg::*;
(
  input  logic                clk,
  input  rock_cell_ctl_t      ctl,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [KEY_BITS-1:0] cmp_key,
  output logic [KEY_BITS-1:0] key_q,
  output logic                match
);

  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (ctl.load) begin
      key_nxt = new_key;
    end else if (ctl.shift) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;
  assign match = (key_r == cmp_key);

endmodule

// ===== hw/rtl/rock_mod.sv =====
// ----------------------------------------------------------------------------
// rock_mod: iterative remainder of the LFSR value by the occupancy
// Restoring remainder, MOD_BITS dividend bits per cycle.
// ----------------------------------------------------------------------------
module rock_mod
  import rock_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LFSR_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [CNT_W-1:0]  rem
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [LFSR_W-1:0] div_r;
  logic [CNT_W-1:0]  dsor_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;

  always_comb begin
    logic [CNT_W:0] r;
    r = {1'b0, rem_r};
    for (int b = 0; b < MOD_BITS; b++) begin
      r = {r[CNT_W-1:0], div_r[LFSR_W-1-b]};
      if (r >= {1'b0, dsor_r}) begin
        r = r - {1'b0, dsor_r};
      end
    end
    rem_nxt = r[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r  <= dividend;
      dsor_r <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      div_r <= div_r << MOD_BITS;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/recency_ordered_key_cache.sv =====
// ----------------------------------------------------------------------------
// recency_ordered_key_cache: fully associative key cache in recency order
// A row of key cells, head = least recent, tail = most recent. Hits move the
// key to the tail, misses append (evicting by policy when full), deletes
// close the gap.
//
//   channel | ports                        | moves
//   --------+------------------------------+--------------------------------
//   in      | in_valid/in_stall/in_data    | item: operation, key
//   out     | out_valid/out_stall/out_data | item: status, eviction, occupancy
//   cfg     | cfg_we/cfg_index/cfg_wdata   | policy, capacity writes
//
// Each item: accept + parallel compare, then shift/load of the row; no new
// item is taken until the row update. A random eviction adds a wait state
// for the remainder unit. Reset: synchronous; empty cache, LFSR seeded, no
// clearing pass. A result waits in the output register; a stalled output
// holds the row update, so at most one item is in flight.
// ----------------------------------------------------------------------------
module recency_ordered_key_cache
  import rock_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rock_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rock_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]          state_r;
  logic [POLICY_W-1:0] policy_r;
  logic [CAP_W-1:0]    cap_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [LFSR_W-1:0]   lfsr_r;
  logic [LFSR_W-1:0]   lfsr_nxt;

  // item held between accept and row update
  logic [KEY_BITS-1:0] key_r;
  logic                remove_r;
  logic                append_r;
  logic                evict_r;
  logic [STATUS_W-1:0] status_r;
  logic [POS_W-1:0]    pos_r;

  logic                out_valid_r;
  rock_out_t           out_data_r;

  // cell row
  logic [KEY_BITS-1:0] cell_key   [CAPACITY];
  logic                cell_match [CAPACITY];
  rock_cell_ctl_t      cell_ctl   [CAPACITY];

  logic                in_fire;
  logic                upd_fire;
  logic                hit;
  logic [POS_W-1:0]    hit_pos;
  logic                is_del;
  logic                evict_now;
  logic                rand_evict;
  logic [CNT_W-1:0]    cnt_m1;
  logic [POS_W-1:0]    victim_pos;
  logic [CNT_W-1:0]    app_cnt;
  logic [POS_W-1:0]    app_pos;
  logic [KEY_BITS-1:0] ev_key;
  logic [STATUS_W-1:0] status_now;

  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  // row update only when the output register is free or draining
  assign upd_fire = (state_r == S_UPD) && (!out_valid_r || !out_stall);

  // --------------------------------------------------------------------------
  // Cells: probe compare against the incoming key in the accept cycle
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] right;
    if (i < CAPACITY - 1) begin : g_mid
      assign right = cell_key[i+1];
    end else begin : g_tail
      assign right = cell_key[i];
    end

    assign cell_ctl[i].shift = upd_fire && remove_r && (POS_W'(i) >= pos_r);
    assign cell_ctl[i].load  = upd_fire && append_r && (POS_W'(i) == app_pos);

    rock_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .right_key (right),
      .new_key   (key_r),
      .cmp_key   (in_data.key),
      .key_q     (cell_key[i]),
      .match     (cell_match[i])
    );
  end

  // first live match from the head; keys are unique, so at most one anyway
  always_comb begin
    logic seen;
    seen    = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_match[i] && (CNT_W'(i) < count_r) && !seen) begin
        hit_pos = POS_W'(i);
      end
      seen = seen | (cell_match[i] && (CNT_W'(i) < count_r));
    end
    hit = seen;
  end

  // --------------------------------------------------------------------------
  // Accept-cycle decisions
  // --------------------------------------------------------------------------
  assign is_del     = (in_data.operation == OP_DELETE);
  assign cnt_m1     = count_r - CNT_W'(1);
  assign evict_now  = !is_del && !hit && (count_r >= rock_limit(cap_r)) && (count_r != '0);
  assign rand_evict = evict_now && (policy_r == POL_RAND);
  assign lfsr_nxt   = rock_lfsr_step(lfsr_r);

  // reserved policy code falls back to least recent
  always_comb begin
    if (policy_r == POL_MRU) begin
      victim_pos = cnt_m1[POS_W-1:0];
    end else begin
      victim_pos = '0;
    end
  end

  always_comb begin
    if (is_del) begin
      status_now = hit ? ST_DEL : ST_ABSENT;
    end else begin
      status_now = hit ? ST_HIT : ST_MISS;
    end
  end

  // random victim = stepped LFSR mod occupancy
  rock_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire && rand_evict),
    .dividend (lfsr_nxt),
    .divisor  (count_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // --------------------------------------------------------------------------
  // Update-cycle values
  // --------------------------------------------------------------------------
  // after a removal the tail slot is one lower
  assign app_cnt   = count_r - CNT_W'(remove_r);
  assign app_pos   = app_cnt[POS_W-1:0];
  assign count_nxt = app_cnt + CNT_W'(append_r);

  always_comb begin
    ev_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_r == POS_W'(i)) begin
        ev_key = ev_key | cell_key[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_LRU;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY:   policy_r <= cfg_wdata[POLICY_W-1:0];
          REG_CAPACITY: cap_r    <= cfg_wdata[CAP_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= rand_evict ? S_MOD : S_UPD;
            if (rand_evict) begin
              lfsr_r <= lfsr_nxt;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_fire) begin
            state_r <= S_IDLE;
            count_r <= count_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item and result payload
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r    <= in_data.key;
      remove_r <= is_del ? hit : (hit || evict_now);
      append_r <= !is_del;
      evict_r  <= evict_now;
      status_r <= status_now;
      pos_r    <= hit ? hit_pos : victim_pos;
    end else if ((state_r == S_MOD) && mod_done) begin
      pos_r <= mod_rem[POS_W-1:0];
    end

    if (upd_fire) begin
      out_data_r.status        <= status_r;
      out_data_r.evicted_valid <= evict_r;
      out_data_r.evicted_key   <= evict_r ? ev_key : '0;
      out_data_r.occupancy     <= OCC_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && out_valid_r && out_stall) |=> $stable(count_r))
    else $error("row updated while result stalled");

  a_mod_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("remainder finished outside wait state");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.evicted_valid) |-> (out_data_r.status == ST_MISS))
    else $error("eviction reported without a miss");

endmodule
